// ----- design/ffha_pkg.sv -----
// Package: constants, types and status codes of the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

   localparam int HEAP_UNITS  = 4096;
   localparam int HDR_UNITS   = 2;
   localparam int SPLIT_UNITS = HDR_UNITS + 2;

   localparam int ADDR_W  = $clog2(HEAP_UNITS);
   localparam int POS_W   = ADDR_W + 1;
   localparam int SIZE_W  = POS_W;
   localparam int UNITS_W = 14;
   localparam int ENTRY_W = SIZE_W + 1;
   localparam int SUM_W   = UNITS_W + 1;

   localparam logic [2:0] ST_ALLOCATED = 3'd0;
   localparam logic [2:0] ST_ZERO      = 3'd1;
   localparam logic [2:0] ST_OOM       = 3'd2;
   localparam logic [2:0] ST_FREED     = 3'd3;
   localparam logic [2:0] ST_IGNORED   = 3'd4;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef struct packed {
      logic               used;
      logic [SIZE_W-1:0]  size;
   } entry_type;

   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      entry_type          data;
   } wr_req_type;

   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
   } rd_req_type;

endpackage

// ----- design/ffha_hdr_ram.sv -----
// Header store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
module ffha_hdr_ram (
   input  logic                  clock,
   input  ffha_pkg::wr_req_type  wr,
   input  ffha_pkg::rd_req_type  rd,
   output ffha_pkg::entry_type   rd_data
);

   ffha_pkg::entry_type mem [ffha_pkg::HEAP_UNITS];
   ffha_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/first_fit_heap_allocator.sv -----
// Top level: first-fit heap allocator over an implicit list of block headers.
// Requests enter on the req_ channel (valid/ready): req_op selects allocate
// (req_request_bytes) or free (req_release_offset). Each transaction yields
// exactly one response on the rsp_ channel with rsp_status and, for a grant,
// rsp_payload_offset. One request is worked at a time; req_ready is high
// only while the block waits for work.
// Zero-size requests and ignored frees go straight to the response
// step. Allocate reads one header per block in a loop (read, then
// check); a split writes the header of the remainder in a further step,
// and an append writes its header at the top. Free first clears the
// flag, then the merge walk reads each block and, after a free block,
// also reads its neighbor to merge it. Every header is read through the
// one read port of the header RAM.
// Reset clears the top mark and the control state; the header RAM is not
// cleared, as only entries written below the top mark are ever read.
// A stalled receiver holds the response in its output register; the next
// request is taken meanwhile and its response waits until the slot frees.
`timescale 1ns / 1ps
module first_fit_heap_allocator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [15:0] req_request_bytes,
   input  logic [15:0] req_release_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [14:0] rsp_payload_offset
);

   localparam int PW = ffha_pkg::POS_W;
   localparam int SW = ffha_pkg::SIZE_W;
   localparam int UW = ffha_pkg::UNITS_W;
   localparam int AW = ffha_pkg::ADDR_W;
   localparam int XW = ffha_pkg::SUM_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_AWALK  = 4'd1;
   localparam logic [3:0] S_ACHK   = 4'd2;
   localparam logic [3:0] S_ASPLIT = 4'd3;
   localparam logic [3:0] S_FCLR   = 4'd4;
   localparam logic [3:0] S_MWALK  = 4'd5;
   localparam logic [3:0] S_MCHK   = 4'd6;
   localparam logic [3:0] S_MNXT   = 4'd7;
   localparam logic [3:0] S_RESP   = 4'd8;

   logic [3:0]    state_ff,       state_in;
   logic [PW-1:0] pos_ff,         pos_in;
   logic [PW-1:0] top_ff,         top_in;
   logic [UW-1:0] units_ff,       units_in;
   logic [SW-1:0] cur_sz_ff,      cur_sz_in;
   logic [PW-1:0] nxt_ff,         nxt_in;
   logic [2:0]    res_status_ff,  res_status_in;
   logic [14:0]   res_off_ff,     res_off_in;
   logic          rsp_valid_ff,   rsp_valid_in;
   logic [2:0]    rsp_status_ff,  rsp_status_in;
   logic [14:0]   rsp_off_ff,     rsp_off_in;

   ffha_pkg::wr_req_type wr;
   ffha_pkg::rd_req_type rd;
   ffha_pkg::entry_type  rd_data;

   logic [16:0]   units_wide;
   logic [UW-1:0] req_units;
   logic [PW-1:0] req_unit;
   logic [PW-1:0] req_hdr;
   logic [PW-1:0] walk_next;
   logic [PW-1:0] merge_sz;
   logic [PW-1:0] merge_nxt;
   logic [XW-1:0] append_end;
   logic [PW-1:0] pay_base;

   ffha_hdr_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   assign units_wide = (17'(req_request_bytes) + 17'd7) >> 3;
   assign req_units  = units_wide[UW-1:0];
   assign req_unit   = req_release_offset[15:3];
   assign req_hdr    = req_unit - PW'(ffha_pkg::HDR_UNITS);
   assign walk_next  = pos_ff + PW'(ffha_pkg::HDR_UNITS) + rd_data.size;
   assign merge_sz   = cur_sz_ff + SW'(ffha_pkg::HDR_UNITS) + rd_data.size;
   assign merge_nxt  = pos_ff + PW'(ffha_pkg::HDR_UNITS) + merge_sz;
   assign append_end = XW'(top_ff) + XW'(ffha_pkg::HDR_UNITS) + XW'(units_ff);

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      top_in        = top_ff;
      units_in      = units_ff;
      cur_sz_in     = cur_sz_ff;
      nxt_in        = nxt_ff;
      res_status_in = res_status_ff;
      res_off_in    = res_off_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      wr            = '0;
      rd            = '0;
      pay_base      = '0;
      req_ready     = (state_ff == S_IDLE);

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_off_in = '0;
               if (req_op == ffha_pkg::OP_ALLOC) begin
                  units_in = req_units;
                  pos_in   = '0;
                  if (req_units == '0) begin
                     res_status_in = ffha_pkg::ST_ZERO;
                     state_in      = S_RESP;
                  end else begin
                     state_in = S_AWALK;
                  end
               end else begin
                  if ((req_release_offset[2:0] != 3'd0) ||
                      (req_unit < PW'(ffha_pkg::HDR_UNITS)) ||
                      (req_hdr >= top_ff)) begin
                     res_status_in = ffha_pkg::ST_IGNORED;
                     state_in      = S_RESP;
                  end else begin
                     pos_in   = req_hdr;
                     rd.en    = 1'b1;
                     rd.addr  = req_hdr[AW-1:0];
                     state_in = S_FCLR;
                  end
               end
            end
         end
         S_AWALK: begin
            if (pos_ff < top_ff) begin
               rd.en    = 1'b1;
               rd.addr  = pos_ff[AW-1:0];
               state_in = S_ACHK;
            end else if (append_end > XW'(ffha_pkg::HEAP_UNITS)) begin
               res_status_in = ffha_pkg::ST_OOM;
               state_in      = S_RESP;
            end else begin
               wr.en         = 1'b1;
               wr.addr       = top_ff[AW-1:0];
               wr.data.used  = 1'b1;
               wr.data.size  = units_ff[SW-1:0];
               pay_base      = top_ff + PW'(ffha_pkg::HDR_UNITS);
               res_off_in    = {pay_base[11:0], 3'b000};
               res_status_in = ffha_pkg::ST_ALLOCATED;
               top_in        = append_end[PW-1:0];
               state_in      = S_RESP;
            end
         end
         S_ACHK: begin
            if (!rd_data.used && (UW'(rd_data.size) >= units_ff)) begin
               wr.en         = 1'b1;
               wr.addr       = pos_ff[AW-1:0];
               wr.data.used  = 1'b1;
               pay_base      = pos_ff + PW'(ffha_pkg::HDR_UNITS);
               res_off_in    = {pay_base[11:0], 3'b000};
               res_status_in = ffha_pkg::ST_ALLOCATED;
               if (XW'(rd_data.size) >= XW'(units_ff) + XW'(ffha_pkg::SPLIT_UNITS)) begin
                  wr.data.size = units_ff[SW-1:0];
                  nxt_in       = pos_ff + PW'(ffha_pkg::HDR_UNITS) + units_ff[PW-1:0];
                  cur_sz_in    = rd_data.size - units_ff[SW-1:0] -
                                 SW'(ffha_pkg::HDR_UNITS);
                  state_in     = S_ASPLIT;
               end else begin
                  wr.data.size = rd_data.size;
                  state_in     = S_RESP;
               end
            end else begin
               pos_in   = walk_next;
               state_in = S_AWALK;
            end
         end
         S_ASPLIT: begin
            wr.en        = 1'b1;
            wr.addr      = nxt_ff[AW-1:0];
            wr.data.used = 1'b0;
            wr.data.size = cur_sz_ff;
            state_in     = S_RESP;
         end
         S_FCLR: begin
            wr.en        = 1'b1;
            wr.addr      = pos_ff[AW-1:0];
            wr.data.used = 1'b0;
            wr.data.size = rd_data.size;
            pos_in       = '0;
            state_in     = S_MWALK;
         end
         S_MWALK: begin
            if (pos_ff < top_ff) begin
               rd.en    = 1'b1;
               rd.addr  = pos_ff[AW-1:0];
               state_in = S_MCHK;
            end else begin
               res_status_in = ffha_pkg::ST_FREED;
               state_in      = S_RESP;
            end
         end
         S_MCHK: begin
            cur_sz_in = rd_data.size;
            nxt_in    = walk_next;
            if (!rd_data.used && (walk_next < top_ff)) begin
               rd.en    = 1'b1;
               rd.addr  = walk_next[AW-1:0];
               state_in = S_MNXT;
            end else begin
               pos_in   = walk_next;
               state_in = S_MWALK;
            end
         end
         S_MNXT: begin
            if (!rd_data.used) begin
               wr.en        = 1'b1;
               wr.addr      = pos_ff[AW-1:0];
               wr.data.used = 1'b0;
               wr.data.size = merge_sz;
               cur_sz_in    = merge_sz;
               nxt_in       = merge_nxt;
               if (merge_nxt < top_ff) begin
                  rd.en    = 1'b1;
                  rd.addr  = merge_nxt[AW-1:0];
               end else begin
                  pos_in   = merge_nxt;
                  state_in = S_MWALK;
               end
            end else begin
               pos_in   = nxt_ff;
               state_in = S_MWALK;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_off_in    = res_off_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      units_ff      <= units_in;
      cur_sz_ff     <= cur_sz_in;
      nxt_ff        <= nxt_in;
      res_status_ff <= res_status_in;
      res_off_ff    <= res_off_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_payload_offset = rsp_off_ff;

endmodule
